### rtl/sorted_range_table_defines.svh
// Assertion macros used by the sorted range table port checker.
`ifndef SORTED_RANGE_TABLE_DEFINES_SVH
`define SORTED_RANGE_TABLE_DEFINES_SVH

// Implication checked on every rising clock edge while reset is released.
`define SRT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sorted_range_table check failed");

// Implication checked on every rising clock edge, reset included.
`define SRT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sorted_range_table check failed");

`endif

### rtl/srt_pkg.sv
// Types and constants shared by the sorted range table and its checker.
`default_nettype none

package srt_pkg;

    // Default sizes of the table.
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int VALUE_WIDTH_DEF   = 32;

    // Fixed widths of the channel fields.
    localparam int FIELD_WIDTH  = 32;
    localparam int ACTION_WIDTH = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 6;

    // Action carried by each input beat; the fourth code is unused.
    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    // Status returned with each result beat.
    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_RANGE = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

endpackage

`default_nettype wire

### rtl/sorted_range_table.sv
// Sorted range table: ordered storage of closed ranges with insert and query.
//
// Usage: each input beat on the s_ channel carries one action. Clear empties
// the table, insert adds [s_range_low, s_range_high] at its ordered place
// (start ascending, equal starts by end descending), and query asks whether
// any stored range holds s_probe_value. Every action returns exactly one
// result beat on the m_ channel with hit, status, entry count, an empty flag
// and the end of the last entry in order.
// The result of a beat accepted at one edge is valid after that edge.
// Throughput is one beat per cycle while m_ready stays high; every entry
// has its own comparators and shift path, so one pass settles any action.
// A bad range (start above end) or an insert into a full table returns an
// error status and leaves the table unchanged.
// Reset empties the table and drops any pending result; no clearing pass is
// needed since entries at or above the count are never looked at.
// While the receiver stalls, the result register holds its beat and
// s_ready stays low until that beat is taken.
`default_nettype none

module sorted_range_table #(
    parameter int TABLE_ENTRIES = srt_pkg::TABLE_ENTRIES_DEF,
    parameter int VALUE_WIDTH   = srt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [srt_pkg::ACTION_WIDTH-1:0] s_action,
    input  wire logic [srt_pkg::FIELD_WIDTH-1:0]  s_range_low,
    input  wire logic [srt_pkg::FIELD_WIDTH-1:0]  s_range_high,
    input  wire logic [srt_pkg::FIELD_WIDTH-1:0]  s_probe_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_hit,
    output logic [srt_pkg::STATUS_WIDTH-1:0]      m_status,
    output logic [srt_pkg::COUNT_WIDTH-1:0]       m_entry_count,
    output logic                                  m_table_empty,
    output logic [srt_pkg::FIELD_WIDTH-1:0]       m_last_end
);
    import srt_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // Table entries and bookkeeping.
    logic [VALUE_WIDTH-1:0] starts_reg [TABLE_ENTRIES];
    logic [VALUE_WIDTH-1:0] ends_reg   [TABLE_ENTRIES];
    logic [CW-1:0]          count_reg, count_next;
    logic [VALUE_WIDTH-1:0] last_reg, last_next;

    // Result register.
    logic                   m_valid_reg;
    logic                   hit_reg, hit_next;
    status_t                status_reg, status_next;
    logic [COUNT_WIDTH-1:0] count_out_reg, count_out_next;
    logic                   empty_reg, empty_next;
    logic [FIELD_WIDTH-1:0] last_out_reg, last_out_next;

    // Per-entry compare results.
    logic [TABLE_ENTRIES-1:0] entry_valid;
    logic [TABLE_ENTRIES-1:0] new_before;
    logic [TABLE_ENTRIES-1:0] probe_inside;
    logic [TABLE_ENTRIES-1:0] slot_open;

    logic [VALUE_WIDTH-1:0] lo_v, hi_v, probe_v;
    logic                   accept;
    logic                   bad_range, table_full, do_insert;

    // Input values are taken modulo the value width.
    assign lo_v    = VALUE_WIDTH'(s_range_low);
    assign hi_v    = VALUE_WIDTH'(s_range_high);
    assign probe_v = VALUE_WIDTH'(s_probe_value);

    // The result register frees up when its beat is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign bad_range  = lo_v > hi_v;
    assign table_full = count_reg >= CW'(TABLE_ENTRIES);
    assign do_insert  = accept && (s_action == ACT_INSERT) && !bad_range && !table_full;

    // One comparator set per entry: ordering against the new range and
    // membership of the probe value.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
        assign entry_valid[g] = CW'(g) < count_reg;
        assign new_before[g]  = entry_valid[g] &&
                                ((lo_v == starts_reg[g]) ? (hi_v > ends_reg[g])
                                                         : (lo_v < starts_reg[g]));
        assign probe_inside[g] = entry_valid[g] && (starts_reg[g] <= probe_v) &&
                                 (probe_v <= ends_reg[g]);
        // Slots from the insert position upward take part in the shift.
        assign slot_open[g] = new_before[g] || !entry_valid[g];

        if (g == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (do_insert && slot_open[g]) begin
                    starts_reg[g] <= lo_v;
                    ends_reg[g]   <= hi_v;
                end
            end
        end else begin : g_rest
            // The first open slot takes the new range, later ones shift up.
            always_ff @(posedge aclk) begin
                if (do_insert && slot_open[g]) begin
                    if (slot_open[g-1]) begin
                        starts_reg[g] <= starts_reg[g-1];
                        ends_reg[g]   <= ends_reg[g-1];
                    end else begin
                        starts_reg[g] <= lo_v;
                        ends_reg[g]   <= hi_v;
                    end
                end
            end
        end
    end

    // Action decode and the next table bookkeeping.
    always_comb begin
        count_next  = count_reg;
        last_next   = last_reg;
        hit_next    = 1'b0;
        status_next = STATUS_OK;
        case (s_action)
            ACT_CLEAR: begin
                count_next = '0;
            end
            ACT_INSERT: begin
                if (bad_range) begin
                    status_next = STATUS_BAD_RANGE;
                end else if (table_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                    // A range placed after every stored one becomes the last.
                    if (!(|new_before)) begin
                        last_next = hi_v;
                    end
                end
            end
            ACT_QUERY: begin
                hit_next = |probe_inside;
            end
            default: begin
            end
        endcase
    end

    // Result fields as they stand after this beat.
    always_comb begin
        count_out_next = COUNT_WIDTH'(count_next);
        empty_next     = (count_next == '0);
        last_out_next  = empty_next ? '0 : FIELD_WIDTH'(last_next);
    end

    // Table bookkeeping registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= last_next;
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hit_reg       <= hit_next;
            status_reg    <= status_next;
            count_out_reg <= count_out_next;
            empty_reg     <= empty_next;
            last_out_reg  <= last_out_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = hit_reg;
    assign m_status      = status_reg;
    assign m_entry_count = count_out_reg;
    assign m_table_empty = empty_reg;
    assign m_last_end    = last_out_reg;

endmodule

`default_nettype wire

### rtl/srt_checker.sv
// Port-level checks for the sorted range table and the bind that attaches them.
`default_nettype none

`include "sorted_range_table_defines.svh"

module srt_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_valid,
    input wire logic                             m_hit,
    input wire logic [srt_pkg::STATUS_WIDTH-1:0] m_status,
    input wire logic [srt_pkg::COUNT_WIDTH-1:0]  m_entry_count,
    input wire logic                             m_table_empty,
    input wire logic [srt_pkg::FIELD_WIDTH-1:0]  m_last_end
);
    import srt_pkg::*;

    // Reset drops any pending result beat.
    `SRT_ASSERT_ALWAYS(a_reset_clears_valid, aclk, (!aresetn |=> !m_valid))

    // An empty table reports a zero count and a zero last end.
    `SRT_ASSERT(a_empty_fields, aclk, aresetn, ((m_valid && m_table_empty) |-> (m_entry_count == '0 && m_last_end == '0)))

    // A rejected insert never reports a hit.
    `SRT_ASSERT(a_error_no_hit, aclk, aresetn, ((m_valid && m_status != STATUS_OK) |-> !m_hit))

    // A hit means the table held at least one range.
    `SRT_ASSERT(a_hit_not_empty, aclk, aresetn, ((m_valid && m_hit) |-> !m_table_empty))

endmodule

bind sorted_range_table srt_checker u_srt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_hit         (m_hit),
    .m_status      (m_status),
    .m_entry_count (m_entry_count),
    .m_table_empty (m_table_empty),
    .m_last_end    (m_last_end)
);

`default_nettype wire

### tb/sv/sorted_range_table_checker.sv
// Checker for the sorted range table: tracks the table contents, predicts every result beat and compares.
`default_nettype none

module sorted_range_table_checker #(
    parameter int TABLE_ENTRIES = srt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire logic [srt_pkg::ACTION_WIDTH-1:0] s_action,
    input  wire logic [srt_pkg::FIELD_WIDTH-1:0]  s_range_low,
    input  wire logic [srt_pkg::FIELD_WIDTH-1:0]  s_range_high,
    input  wire logic [srt_pkg::FIELD_WIDTH-1:0]  s_probe_value,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire logic                             m_hit,
    input  wire logic [srt_pkg::STATUS_WIDTH-1:0] m_status,
    input  wire logic [srt_pkg::COUNT_WIDTH-1:0]  m_entry_count,
    input  wire logic                             m_table_empty,
    input  wire logic [srt_pkg::FIELD_WIDTH-1:0]  m_last_end,
    output int unsigned                           error_count,
    output int unsigned                           pending_results,
    output int unsigned                           hit_count,
    output int unsigned                           full_count,
    output int unsigned                           bad_range_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import srt_pkg::*;

    // One result beat as the table should report it.
    typedef struct packed {
        logic                   hit;
        status_t                status;
        logic [COUNT_WIDTH-1:0] entry_count;
        logic                   table_empty;
        logic [FIELD_WIDTH-1:0] last_end;
    } table_result_t;

    // Shadow copy of the table contents.
    logic [FIELD_WIDTH-1:0] shadow_start [TABLE_ENTRIES];
    logic [FIELD_WIDTH-1:0] shadow_end   [TABLE_ENTRIES];
    int                     shadow_total;

    // Results still owed by the block, oldest first.
    table_result_t          owed_results [$];

    // True if range (lo, hi) belongs strictly ahead of range (s, e) in table order.
    function automatic logic sorts_ahead(input logic [FIELD_WIDTH-1:0] lo, hi, s, e);
        return (lo == s) ? (hi > e) : (lo < s);
    endfunction

    // Applies one beat to the shadow table and returns the result it should produce.
    function automatic table_result_t apply_beat(input logic [ACTION_WIDTH-1:0] act,
                                                 input logic [FIELD_WIDTH-1:0] lo, hi, probe);
        table_result_t r;
        int            slot;
        r = '0;
        r.status = STATUS_OK;
        case (act)
            ACT_CLEAR: begin
                shadow_total = 0;
            end
            ACT_INSERT: begin
                if (lo > hi) begin
                    r.status = STATUS_BAD_RANGE;
                end else if (shadow_total >= TABLE_ENTRIES) begin
                    r.status = STATUS_FULL;
                end else begin
                    // The new range goes ahead of the first entry that it sorts before.
                    slot = shadow_total;
                    for (int i = 0; i < shadow_total; i++) begin
                        if (slot == shadow_total && sorts_ahead(lo, hi, shadow_start[i],
                                                                shadow_end[i])) begin
                            slot = i;
                        end
                    end
                    for (int i = shadow_total; i > slot; i--) begin
                        shadow_start[i] = shadow_start[i-1];
                        shadow_end[i]   = shadow_end[i-1];
                    end
                    shadow_start[slot] = lo;
                    shadow_end[slot]   = hi;
                    shadow_total++;
                end
            end
            ACT_QUERY: begin
                for (int i = 0; i < shadow_total; i++) begin
                    if (shadow_start[i] <= probe && probe <= shadow_end[i]) begin
                        r.hit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = shadow_total[COUNT_WIDTH-1:0];
        r.table_empty = (shadow_total == 0);
        r.last_end    = (shadow_total > 0) ? shadow_end[shadow_total-1] : '0;
        return r;
    endfunction

    // Reports one field that differs and returns 1 in that case.
    function automatic int unsigned field_mismatch(input string name,
                                                   input logic [FIELD_WIDTH-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Result beats are checked before the input beat of the same edge is predicted,
    // since a result can never belong to the beat accepted at that very edge.
    always @(posedge aclk) begin
        table_result_t want;
        if (!aresetn) begin
            shadow_total = 0;
            owed_results.delete();
            error_count     = 0;
            hit_count       = 0;
            full_count      = 0;
            bad_range_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result beat arrived with no result expected");
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    error_count += field_mismatch("m_hit", FIELD_WIDTH'(want.hit),
                                                  FIELD_WIDTH'(m_hit));
                    error_count += field_mismatch("m_status", FIELD_WIDTH'(want.status),
                                                  FIELD_WIDTH'(m_status));
                    error_count += field_mismatch("m_entry_count",
                                                  FIELD_WIDTH'(want.entry_count),
                                                  FIELD_WIDTH'(m_entry_count));
                    error_count += field_mismatch("m_table_empty",
                                                  FIELD_WIDTH'(want.table_empty),
                                                  FIELD_WIDTH'(m_table_empty));
                    error_count += field_mismatch("m_last_end", want.last_end, m_last_end);
                end
            end
            if (s_valid && s_ready) begin
                want = apply_beat(s_action, s_range_low, s_range_high, s_probe_value);
                owed_results.insert(owed_results.size(), want);
                if (want.hit) hit_count++;
                if (want.status == STATUS_FULL) full_count++;
                if (want.status == STATUS_BAD_RANGE) bad_range_count++;
            end
        end
        pending_results <= owed_results.size();
    end

endmodule

`default_nettype wire

### tb/sv/sorted_range_table_test.sv
// Top of the sorted range table testbench: clock, reset, stimulus, result sink and verdict.
`default_nettype none

module sorted_range_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srt_pkg::*;

    localparam int unsigned RANDOM_ITEMS     = 1600;
    localparam int unsigned MAX_GAP          = 6;
    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam logic [ACTION_WIDTH-1:0] ACT_RESERVED = 2'd3;
    localparam logic [FIELD_WIDTH-1:0]  ALL_ONES     = 32'hFFFF_FFFF;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [ACTION_WIDTH-1:0] s_action      = ACT_CLEAR;
    logic [FIELD_WIDTH-1:0]  s_range_low   = '0;
    logic [FIELD_WIDTH-1:0]  s_range_high  = '0;
    logic [FIELD_WIDTH-1:0]  s_probe_value = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic                    m_hit;
    logic [STATUS_WIDTH-1:0] m_status;
    logic [COUNT_WIDTH-1:0]  m_entry_count;
    logic                    m_table_empty;
    logic [FIELD_WIDTH-1:0]  m_last_end;

    int unsigned error_count;
    int unsigned pending_results;
    int unsigned hit_count;
    int unsigned full_count;
    int unsigned bad_range_count;

    int unsigned cycle_count = 0;
    int unsigned beats_by_action [4];
    int unsigned random_beats = 0;
    bit          quiet_mode = 1'b0;
    bit          long_hold_req = 1'b0;

    sorted_range_table i_dut (.*);

    sorted_range_table_checker i_checker (.*);

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle counter and watchdog.
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Result sink: a random wait before each beat, and a long hold-off when asked.
    initial begin
        int unsigned gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end
            gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offers one input beat after a random gap and returns once it is accepted.
    task automatic send_beat(input logic [ACTION_WIDTH-1:0] act,
                             input logic [FIELD_WIDTH-1:0] lo, hi, probe);
        int unsigned gap;
        gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_range_low   <= lo;
        s_range_high  <= hi;
        s_probe_value <= probe;
        do @(posedge aclk); while (!s_ready);
        beats_by_action[act]++;
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    // Values weighted toward small numbers and both ends of the field.
    function automatic logic [FIELD_WIDTH-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom_range(0, 63);
        if (roll < 55) return $urandom_range(0, 4095);
        if (roll < 75) return $urandom;
        if (roll < 85) return ALL_ONES - $urandom_range(0, 63);
        if (roll < 92) return '0;
        return ALL_ONES;
    endfunction

    // Mostly narrow well-formed ranges, some single values, some wide, some reversed.
    function automatic void pick_range(output logic [FIELD_WIDTH-1:0] lo, hi);
        int unsigned            roll;
        logic [FIELD_WIDTH-1:0] swap;
        roll = $urandom_range(0, 99);
        lo = pick_value();
        hi = pick_value();
        if (roll < 55) begin
            hi = lo + $urandom_range(0, 64);
            if (hi < lo) hi = ALL_ONES;
        end else if (roll < 65) begin
            hi = lo;
        end else if (roll < 88) begin
            if (hi < lo) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
        end else begin
            // Start above end.
            if (lo < hi) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            if (lo == hi) begin
                if (lo == 0) lo = 1;
                else hi = lo - 1;
            end
        end
    endfunction

    // Stimulus and verdict.
    initial begin
        logic [FIELD_WIDTH-1:0] lo;
        logic [FIELD_WIDTH-1:0] hi;
        logic [FIELD_WIDTH-1:0] probe;
        logic [FIELD_WIDTH-1:0] last_low;
        int unsigned            roll;
        int unsigned            ops;
        bit                     fill;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats: empty table, reversed ranges, extremes, equal starts and
        // equal ranges, the unused action code and the edges of a stored range.
        send_beat(ACT_QUERY, '0, '0, '0);
        send_beat(ACT_INSERT, 32'd1, 32'd0, '0);
        send_beat(ACT_INSERT, ALL_ONES, '0, ALL_ONES);
        send_beat(ACT_INSERT, '0, ALL_ONES, '0);
        send_beat(ACT_QUERY, '0, '0, ALL_ONES);
        send_beat(ACT_INSERT, 32'd5, 32'd10, '0);
        send_beat(ACT_INSERT, 32'd5, 32'd20, '0);
        send_beat(ACT_INSERT, 32'd5, 32'd10, '0);
        send_beat(ACT_INSERT, ALL_ONES, ALL_ONES, '0);
        send_beat(ACT_INSERT, 32'd3, 32'd3, '0);
        send_beat(ACT_QUERY, ALL_ONES, ALL_ONES, 32'd7);
        send_beat(ACT_RESERVED, ALL_ONES, ALL_ONES, ALL_ONES);
        send_beat(ACT_CLEAR, ALL_ONES, '0, ALL_ONES);
        send_beat(ACT_QUERY, '0, '0, '0);
        send_beat(ACT_INSERT, 32'd100, 32'd200, '0);
        send_beat(ACT_QUERY, '0, '0, 32'd99);
        send_beat(ACT_QUERY, '0, '0, 32'd100);
        send_beat(ACT_QUERY, '0, '0, 32'd200);
        send_beat(ACT_QUERY, '0, '0, 32'd201);
        send_beat(ACT_INSERT, '0, '0, '0);
        send_beat(ACT_QUERY, '0, '0, '0);
        send_beat(ACT_CLEAR, '0, '0, '0);
        wait_for_results();

        // Random episodes, each starting from a cleared table. Fill episodes are
        // mostly inserts so that the table runs full.
        last_low = '0;
        for (int ep = 0; random_beats < RANDOM_ITEMS; ep++) begin
            fill       = (ep == 0) || ($urandom_range(0, 3) == 0);
            quiet_mode = ($urandom_range(0, 4) == 0);
            if (ep == 2 || ep == 9) long_hold_req = 1'b1;
            send_beat(ACT_CLEAR, $urandom, $urandom, $urandom);
            random_beats++;
            ops = fill ? $urandom_range(40, 52) : $urandom_range(4, 40);
            repeat (ops) begin
                roll = $urandom_range(0, 99);
                if (roll < (fill ? 90 : 50)) begin
                    pick_range(lo, hi);
                    last_low = lo;
                    send_beat(ACT_INSERT, lo, hi, $urandom);
                end else if (roll < 97) begin
                    // Probe near a recent start about a third of the time.
                    if ($urandom_range(0, 2) == 0) probe = last_low + $urandom_range(0, 8);
                    else probe = pick_value();
                    send_beat(ACT_QUERY, $urandom, $urandom, probe);
                end else if (roll < 99) begin
                    send_beat(ACT_CLEAR, $urandom, $urandom, $urandom);
                end else begin
                    send_beat(ACT_RESERVED, $urandom, $urandom, $urandom);
                end
                random_beats++;
            end
            if (ep == 1 || $urandom_range(0, 3) == 0) wait_for_results();
        end

        quiet_mode = 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d clears, %0d inserts, %0d queries and %0d unused-code beats.",
                 beats_by_action[ACT_CLEAR], beats_by_action[ACT_INSERT],
                 beats_by_action[ACT_QUERY], beats_by_action[ACT_RESERVED]);
        $display("Results covered %0d hits, %0d full-table and %0d reversed-range rejects.",
                 hit_count, full_count, bad_range_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/srt_pkg.sv
rtl/sorted_range_table.sv
rtl/srt_checker.sv
tb/sv/sorted_range_table_checker.sv
tb/sv/sorted_range_table_test.sv
